FILE: rtl/apul_pkg.sv
// ----------------------------------------------------------------------------
// apul_pkg
// Shared types and codes of the sample pair unpacker and level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package apul_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int SQUARE_W  = 48;
  localparam int BLOCK_E_W = 56;
  localparam int WIN_E_W   = 61;

  localparam logic CMD_PAIR = 1'b0;
  localparam logic CMD_EOB  = 1'b1;

  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_METER = 1'b1;

  localparam logic REG_ACTIVE_CHANNELS = 1'b0;
  localparam logic REG_MEASURE_ENABLE  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
  } in_t;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic [4:0]                 pair_number;
    logic [5:0]                 channel;
    logic [WIN_E_W-1:0]         window_energy;
    logic [SAMPLE_W-1:0]        window_peak;
    logic                       last;
  } out_t;

  // One classified item waiting for the back end.
  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [4:0]          pair;
  } work_t;

  typedef struct packed {
    logic [5:0] pairs;
    logic       measure;
  } cfg_t;

  // Block accumulators of one channel pair.
  typedef struct packed {
    logic [BLOCK_E_W-1:0] e_l;
    logic [BLOCK_E_W-1:0] e_r;
    logic [SAMPLE_W-1:0]  p_l;
    logic [SAMPLE_W-1:0]  p_r;
  } blk_t;

endpackage

`default_nettype wire

FILE: rtl/apul_front.sv
// ----------------------------------------------------------------------------
// apul_front
// Accepts items, unpacks the sample bytes and tracks the pair position.
// ----------------------------------------------------------------------------
`default_nettype none

module apul_front import apul_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  clearing_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire in_t   in_data_i,
  output logic       push_o,
  input  wire logic  push_ready_i,
  output work_t      push_data_o
);

  logic [4:0] pos_q, pos_d;
  logic [4:0] pos_use;
  logic [5:0] pos_inc;
  logic       xfer;

  assign in_ready_o = push_ready_i & ~clearing_i;
  assign xfer       = in_valid_i & in_ready_o;

  // Wrap a stale position before use.
  assign pos_use = ({1'b0, pos_q} >= cfg_i.pairs) ? 5'd0 : pos_q;
  assign pos_inc = {1'b0, pos_use} + 6'd1;

  always_comb begin
    pos_d = pos_q;
    if (xfer) begin
      if (in_data_i.command == CMD_EOB) begin
        pos_d = 5'd0;
      end else begin
        pos_d = (pos_inc >= cfg_i.pairs) ? 5'd0 : pos_inc[4:0];
      end
    end
  end

  always_comb begin
    push_data_o.cmd   = in_data_i.command;
    push_data_o.left  = {in_data_i.byte_1, in_data_i.byte_0, in_data_i.byte_3};
    push_data_o.right = {in_data_i.byte_2, in_data_i.byte_5, in_data_i.byte_4};
    push_data_o.pair  = (in_data_i.command == CMD_EOB) ? 5'd0 : pos_use;
    // Drop an end of block when metering is off.
    push_o = xfer & ((in_data_i.command == CMD_PAIR) | cfg_i.measure);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 5'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/apul_fifo.sv
// ----------------------------------------------------------------------------
// apul_fifo
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module apul_fifo import apul_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  output logic       push_ready_o,
  input  wire work_t push_data_i,
  output logic       pop_valid_o,
  input  wire logic  pop_i,
  output work_t      pop_data_o
);

  work_t      mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/apul_back.sv
// ----------------------------------------------------------------------------
// apul_back
// Squares and accumulates samples, keeps the history ring, walks the window.
// ----------------------------------------------------------------------------
`default_nettype none

module apul_back import apul_pkg::*; #(
  parameter int MAX_CHANNELS  = 40,
  parameter int WINDOW_BLOCKS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  output logic       clearing_o,
  input  wire logic  wk_valid_i,
  output logic       wk_pop_o,
  input  wire work_t wk_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_t       out_data_o
);

  localparam int Pairs = MAX_CHANNELS / 2;
  localparam int PW    = (Pairs > 1) ? $clog2(Pairs) : 1;
  localparam int HD    = MAX_CHANNELS * WINDOW_BLOCKS;
  localparam int AW    = $clog2(HD);
  localparam int SW    = $clog2(WINDOW_BLOCKS);
  localparam int VW    = $clog2(WINDOW_BLOCKS + 1);

  typedef enum logic [7:0] {
    ST_CLR  = 8'b0000_0001,
    ST_IDLE = 8'b0000_0010,
    ST_SQ   = 8'b0000_0100,
    ST_ACC  = 8'b0000_1000,
    ST_EWR  = 8'b0001_0000,
    ST_SCAN = 8'b0010_0000,
    ST_EMIT = 8'b0100_0000,
    ST_SPARE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  work_t               wk_q, wk_d;
  logic [SQUARE_W-1:0] sq_l_q, sq_l_d, sq_r_q, sq_r_d;
  logic [SAMPLE_W-1:0] mag_l_q, mag_l_d, mag_r_q, mag_r_d;
  logic [SAMPLE_W-1:0] mag_l, mag_r;
  logic [5:0]          ch_q, ch_d;
  logic [6:0]          ch_inc;
  logic [AW-1:0]       base_q, base_d;
  logic [VW-1:0]       v_q, v_d;
  logic [WIN_E_W-1:0]  sum_q, sum_d;
  logic [SAMPLE_W-1:0] pk_q, pk_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;
  logic                out_free;
  logic [6:0]          nch;

  // Block accumulator store, one row per channel pair.
  blk_t                blk_mem [Pairs];
  logic [Pairs-1:0]    blk_vld_q;
  blk_t                blk_rd_q;
  logic                blk_rdv_q;
  blk_t                blk_cur, blk_wdata;
  logic [PW-1:0]       blk_raddr;
  logic                blk_we, blk_clr;

  // History ring, one row of WINDOW_BLOCKS slots per channel.
  logic [BLOCK_E_W-1:0] hist_e_mem [HD];
  logic [SAMPLE_W-1:0]  hist_p_mem [HD];
  logic [BLOCK_E_W-1:0] hist_rd_e_q, hist_we_e;
  logic [SAMPLE_W-1:0]  hist_rd_p_q, hist_we_p;
  logic [AW-1:0]        hist_waddr, hist_raddr;
  logic                 hist_we;

  logic [BLOCK_E_W:0]   acc_e_l, acc_e_r;
  logic [WIN_E_W:0]     acc_w;

  assign nch        = {cfg_i.pairs, 1'b0};
  assign ch_inc     = {1'b0, ch_q} + 7'd1;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign clearing_o = (state_q == ST_CLR);
  assign blk_cur    = blk_rdv_q ? blk_rd_q : '0;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Magnitude of a 24-bit two's complement sample; full negative scale stays.
  assign mag_l = wk_q.left[SAMPLE_W-1]  ? (~wk_q.left + 24'd1)  : wk_q.left;
  assign mag_r = wk_q.right[SAMPLE_W-1] ? (~wk_q.right + 24'd1) : wk_q.right;

  assign acc_e_l = {1'b0, blk_cur.e_l} + (BLOCK_E_W+1)'(sq_l_q);
  assign acc_e_r = {1'b0, blk_cur.e_r} + (BLOCK_E_W+1)'(sq_r_q);
  assign acc_w   = {1'b0, sum_q} + (WIN_E_W+1)'(hist_rd_e_q);

  always_comb begin
    state_d     = state_q;
    wk_d        = wk_q;
    sq_l_d      = sq_l_q;
    sq_r_d      = sq_r_q;
    mag_l_d     = mag_l_q;
    mag_r_d     = mag_r_q;
    ch_d        = ch_q;
    base_d      = base_q;
    v_d         = v_q;
    sum_d       = sum_q;
    pk_d        = pk_q;
    slot_d      = slot_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    wk_pop_o    = 1'b0;
    blk_raddr   = PW'(wk_q.pair);
    blk_we      = 1'b0;
    blk_clr     = 1'b0;
    blk_wdata   = blk_cur;
    hist_we     = 1'b0;
    hist_waddr  = AW'(ch_q * WINDOW_BLOCKS + slot_q);
    hist_we_e   = '0;
    hist_we_p   = '0;
    hist_raddr  = base_q;

    case (state_q)
      ST_CLR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_q;
        clr_d      = clr_q + AW'(1);
        if (clr_q == AW'(HD - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        blk_raddr = PW'(wk_i.pair);
        if (wk_valid_i) begin
          wk_pop_o = 1'b1;
          wk_d     = wk_i;
          ch_d     = 6'd0;
          state_d  = (wk_i.cmd == CMD_PAIR) ? ST_SQ : ST_EWR;
        end
      end
      ST_SQ: begin
        mag_l_d = mag_l;
        mag_r_d = mag_r;
        sq_l_d  = mag_l * mag_l;
        sq_r_d  = mag_r * mag_r;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (out_free) begin
          blk_we          = 1'b1;
          blk_wdata.e_l   = acc_e_l[BLOCK_E_W] ? '1 : acc_e_l[BLOCK_E_W-1:0];
          blk_wdata.e_r   = acc_e_r[BLOCK_E_W] ? '1 : acc_e_r[BLOCK_E_W-1:0];
          blk_wdata.p_l   = (mag_l_q > blk_cur.p_l) ? mag_l_q : blk_cur.p_l;
          blk_wdata.p_r   = (mag_r_q > blk_cur.p_r) ? mag_r_q : blk_cur.p_r;
          out_valid_d     = 1'b1;
          out_d           = '0;
          out_d.kind      = KIND_PAIR;
          out_d.sample_left  = wk_q.left;
          out_d.sample_right = wk_q.right;
          out_d.pair_number  = wk_q.pair;
          state_d         = ST_IDLE;
        end
      end
      ST_EWR: begin
        // Store this channel's block result in the current slot.
        hist_we   = 1'b1;
        hist_we_e = ch_q[0] ? blk_cur.e_r : blk_cur.e_l;
        hist_we_p = ch_q[0] ? blk_cur.p_r : blk_cur.p_l;
        blk_clr   = ch_q[0];
        base_d    = AW'(ch_q * WINDOW_BLOCKS);
        v_d       = '0;
        sum_d     = '0;
        pk_d      = '0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        if (v_q != VW'(WINDOW_BLOCKS)) begin
          hist_raddr = base_q + AW'(v_q);
        end
        v_d = v_q + VW'(1);
        if (v_q != '0) begin
          sum_d = acc_w[WIN_E_W] ? '1 : acc_w[WIN_E_W-1:0];
          pk_d  = (hist_rd_p_q > pk_q) ? hist_rd_p_q : pk_q;
        end
        if (v_q == VW'(WINDOW_BLOCKS)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        blk_raddr = ch_inc[PW:1];
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d               = '0;
          out_d.kind          = KIND_METER;
          out_d.channel       = ch_q;
          out_d.window_energy = sum_q;
          out_d.window_peak   = pk_q;
          out_d.last          = (ch_inc == nch);
          if (ch_inc == nch) begin
            slot_d  = (slot_q == SW'(WINDOW_BLOCKS - 1)) ? '0 : slot_q + SW'(1);
            state_d = ST_IDLE;
          end else begin
            ch_d    = ch_inc[5:0];
            state_d = ST_EWR;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[PW'(wk_q.pair)] <= blk_wdata;
    end
    blk_rd_q <= blk_mem[blk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_e_mem[hist_waddr] <= hist_we_e;
      hist_p_mem[hist_waddr] <= hist_we_p;
    end
    hist_rd_e_q <= hist_e_mem[hist_raddr];
    hist_rd_p_q <= hist_p_mem[hist_raddr];
  end

  always_ff @(posedge clk_i) begin
    wk_q    <= wk_d;
    sq_l_q  <= sq_l_d;
    sq_r_q  <= sq_r_d;
    mag_l_q <= mag_l_d;
    mag_r_q <= mag_r_d;
    base_q  <= base_d;
    sum_q   <= sum_d;
    pk_q    <= pk_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      ch_q        <= 6'd0;
      v_q         <= '0;
      slot_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      blk_vld_q   <= '0;
      blk_rdv_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      v_q         <= v_d;
      slot_q      <= slot_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      blk_rdv_q   <= blk_vld_q[blk_raddr];
      if (blk_we) begin
        blk_vld_q[PW'(wk_q.pair)] <= 1'b1;
      end else if (blk_clr) begin
        blk_vld_q[ch_q[PW:1]] <= 1'b0;
      end
    end
  end

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !wk_pop_o)
    else $error("queue popped during history clear");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (v_q <= VW'(WINDOW_BLOCKS)))
    else $error("window scan ran past the ring");

  a_last_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && out_free && (ch_inc == nch)) |=> (state_q == ST_IDLE))
    else $error("end of block did not finish on last reading");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: rtl/audio_pair_unpack_level_meter.sv
// ----------------------------------------------------------------------------
// audio_pair_unpack_level_meter
// Unpacks 24-bit sample pairs and keeps per-channel block and window meters.
// ----------------------------------------------------------------------------
//  channel   | handshake                | payload
//  input     | in_valid_i / in_ready_o  | in_data_i   (in_t)
//  output    | out_valid_o / out_ready_i| out_data_o  (out_t)
//  config    | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
//  In the back end a sample pair is popped, squared, then accumulated into
//  the pair's row of the block store, and the result is posted.
//  During an end of block the window walk reads the history ring one slot
//  per cycle through its single read port.
//  After reset the history ring is zeroed while in_ready_o stays low;
//  config writes are taken as ever.
//  A two-entry queue lets the front keep taking transfers while the back
//  end or the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_pair_unpack_level_meter import apul_pkg::*; #(
  parameter int MAX_CHANNELS  = 40,
  parameter int WINDOW_BLOCKS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [5:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_t        in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_t            out_data_o
);

  localparam int MaxPairs = MAX_CHANNELS / 2;

  logic [5:0] active_q, active_d;
  logic       measure_q, measure_d;
  logic [4:0] half;
  cfg_t       cfg;

  logic  push, push_ready, pop_valid, pop, clearing;
  work_t push_data, pop_data;

  // Hold config; the user must write only while idle, the block does not enforce it.
  always_comb begin
    active_d  = active_q;
    measure_d = measure_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACTIVE_CHANNELS: active_d  = cfg_wdata_i;
        REG_MEASURE_ENABLE:  measure_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 6'd40;
      measure_q <= 1'b1;
    end else begin
      active_q  <= active_d;
      measure_q <= measure_d;
    end
  end

  // Pair count: half the channels, at least one, at most the built maximum.
  assign half = active_q[5:1];
  always_comb begin
    cfg.measure = measure_q;
    if (half == 5'd0) begin
      cfg.pairs = 6'd1;
    end else if ({1'b0, half} > 6'(MaxPairs)) begin
      cfg.pairs = 6'(MaxPairs);
    end else begin
      cfg.pairs = {1'b0, half};
    end
  end

  apul_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .clearing_i   (clearing),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  apul_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  apul_back #(
    .MAX_CHANNELS  (MAX_CHANNELS),
    .WINDOW_BLOCKS (WINDOW_BLOCKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .clearing_o  (clearing),
    .wk_valid_i  (pop_valid),
    .wk_pop_o    (pop),
    .wk_i        (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
